/* sv/vic_pkg.sv */
// ----------------------------------------------------------------------------
// vic_pkg
// Shared types and constants for the velocity integrator with speed clamp.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [2:0] OP_DIR_ACC  = 3'd0;
  localparam logic [2:0] OP_VEC_ACC  = 3'd1;
  localparam logic [2:0] OP_STEP     = 3'd2;
  localparam logic [2:0] OP_LOAD_VEL = 3'd3;
  localparam logic [2:0] OP_LOAD_ACC = 3'd4;

  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_UP    = 3'd2;
  localparam logic [2:0] DIR_DOWN  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;
  localparam logic [2:0] DIR_LEFT  = 3'd5;

  localparam logic [2:0] REG_UP_AXIS   = 3'd0;
  localparam logic [2:0] REG_FWD_AXIS  = 3'd1;
  localparam logic [2:0] REG_RIGHT_AXIS = 3'd2;
  localparam logic [2:0] REG_MAX_SPEED = 3'd3;

  localparam logic [47:0] UP_AXIS_RST    = 48'h0000_4000_0000;
  localparam logic [47:0] FWD_AXIS_RST   = 48'h4000_0000_0000;
  localparam logic [47:0] RIGHT_AXIS_RST = 48'h0000_0000_4000;
  localparam logic [30:0] MAX_SPEED_RST  = 31'd0;

  localparam int RD_NUM_W = 64;
  localparam int RD_DEN_W = 34;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [2:0]         direction;
    logic signed [31:0] amount;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic [15:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic signed [31:0] acc_z;
  } out_word_t;

  typedef struct packed {
    logic                start;
    logic                is_div;
    logic [RD_NUM_W-1:0] num;
    logic [RD_DEN_W-1:0] den;
  } rd_ctrl_t;

  typedef struct packed {
    logic                done;
    logic [RD_NUM_W-1:0] res;
  } rd_stat_t;

endpackage

/* sv/vic_mul.sv */
// ----------------------------------------------------------------------------
// vic_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module vic_mul #(
  parameter int AW = 33
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [32:0]   b,
  output logic signed [AW+32:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* sv/vic_rdiv.sv */
// ----------------------------------------------------------------------------
// vic_rdiv
// Bit-serial unit: 32-step integer square root or 64-step restoring divide.
// ----------------------------------------------------------------------------
module vic_rdiv (
  input  logic              clk,
  input  logic              rst,
  input  vic_pkg::rd_ctrl_t ctrl,
  output vic_pkg::rd_stat_t stat
);

  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] b;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic        mode_div;
  logic [63:0] den;
  logic [63:0] rb;
  logic [63:0] sh;

  assign rb = r + b;
  assign sh = {r[62:0], n[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy     <= 1'b1;
        mode_div <= ctrl.is_div;
        n        <= ctrl.num;
        r        <= '0;
        b        <= 64'h4000_0000_0000_0000;
        den      <= 64'(ctrl.den);
        cnt      <= ctrl.is_div ? 7'd64 : 7'd32;
      end else if (busy) begin
        if (mode_div) begin
          if (sh >= den) begin
            r <= sh - den;
            n <= {n[62:0], 1'b1};
          end else begin
            r <= sh;
            n <= {n[62:0], 1'b0};
          end
        end else begin
          if (n >= rb) begin
            n <= n - rb;
            r <= (r >> 1) + b;
          end else begin
            r <= r >> 1;
          end
          b <= b >> 2;
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.res  = mode_div ? n : r;

endmodule

/* sv/velocity_integrator_speed_clamp.sv */
// ----------------------------------------------------------------------------
// velocity_integrator_speed_clamp
// Semi-implicit Euler velocity integrator with optional speed clamp.
// ----------------------------------------------------------------------------
// One word in, one word out; the block takes no new word until the result is
// taken. A step that clamps runs squares through the shared multiplier, a
// square root and three divides on the shared shift/subtract unit; when no
// component alone exceeds the limit, the sum of squares is first compared
// with the squared limit, and wide values are prescaled by a right shift.
module velocity_integrator_speed_clamp #(
  parameter int VALUE_WIDTH = vic_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  vic_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output vic_pkg::out_word_t out_word,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  localparam int W  = VALUE_WIDTH;
  localparam int AW = (W + 1 > 33) ? W + 1 : 33;
  localparam int PW = AW + 33;
  localparam int KW = $clog2(W);
  localparam logic signed [PW-1:0] VMAX_P = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [PW-1:0] VMIN_P = ~VMAX_P;

  typedef enum logic [4:0] {
    S_IDLE, S_AX_ISS, S_AX_TAKE, S_VACC, S_VADD, S_CHK, S_SQ_ISS, S_SQ_TAKE,
    S_SHIFT, S_SQ2_ISS, S_SQ2_TAKE, S_ROOT_GO, S_ROOT_WAIT, S_DM_ISS,
    S_DM_TAKE, S_DIV_WAIT, S_DP_ISS, S_DP_TAKE, S_OUT
  } state_t;

  function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
    logic signed [W-1:0] res;
    if (v > VMAX_P) res = VMAX_P[W-1:0];
    else if (v < VMIN_P) res = VMIN_P[W-1:0];
    else res = v[W-1:0];
    return res;
  endfunction

  function automatic logic [W:0] mag(input logic signed [W-1:0] v);
    logic signed [W:0] e;
    e = {v[W-1], v};
    return (e < 0) ? (W+1)'(0) - e : e;
  endfunction

  state_t state;
  vic_pkg::in_word_t cur;
  logic [47:0] up_axis;
  logic [47:0] forward_axis;
  logic [47:0] right_axis;
  logic [30:0] max_speed;
  logic signed [W-1:0] vel  [3];
  logic signed [W-1:0] acc  [3];
  logic signed [W-1:0] disp [3];
  logic [32:0] s_mag [3];
  logic        s_neg [3];
  logic [1:0]  idx;
  logic [KW-1:0] k;
  logic [63:0] sum;
  logic [33:0] len;

  logic signed [AW-1:0] mul_a;
  logic signed [32:0]   mul_b;
  logic signed [PW-1:0] mul_p;
  vic_pkg::rd_ctrl_t rd_ctrl;
  vic_pkg::rd_stat_t rd_stat;

  logic [47:0] axis_sel;
  logic        dir_ok;
  logic        dir_neg;
  logic signed [15:0] axis_c;
  logic signed [32:0] amt_s;
  logic signed [31:0] vec_c;
  logic signed [W-1:0] sh_v [3];
  logic [W:0]  sh_m [3];
  logic        big;
  logic        over;
  logic signed [PW-1:0] q_val;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cfg_ready = 1'b1;

  always_comb begin
    dir_ok = 1'b1;
    axis_sel = forward_axis;
    unique case (cur.direction)
      vic_pkg::DIR_FWD, vic_pkg::DIR_BACK:   axis_sel = forward_axis;
      vic_pkg::DIR_UP, vic_pkg::DIR_DOWN:    axis_sel = up_axis;
      vic_pkg::DIR_RIGHT, vic_pkg::DIR_LEFT: axis_sel = right_axis;
      default: dir_ok = 1'b0;
    endcase
    dir_neg = cur.direction[0];
    axis_c  = axis_sel[16*idx +: 16];
    amt_s   = dir_neg ? -33'(cur.amount) : 33'(cur.amount);
    unique case (idx)
      2'd0: vec_c = cur.vec_x;
      2'd1: vec_c = cur.vec_y;
      default: vec_c = cur.vec_z;
    endcase
  end

  always_comb begin
    big  = 1'b0;
    over = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sh_v[i] = vel[i] >>> k;
      sh_m[i] = mag(sh_v[i]);
      if (64'(sh_m[i]) > 64'h8000_0000) big = 1'b1;
      if (64'(mag(vel[i])) > 64'(max_speed)) over = 1'b1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_AX_ISS: begin
        mul_a = AW'(axis_c);
        mul_b = amt_s;
      end
      S_SQ_ISS: begin
        mul_a = (idx == 2'd3) ? AW'(max_speed) : AW'(mag(vel[idx]));
        mul_b = (idx == 2'd3) ? 33'(max_speed) : 33'(mag(vel[idx]));
      end
      S_SQ2_ISS: begin
        mul_a = AW'(s_mag[idx]);
        mul_b = s_mag[idx];
      end
      S_DM_ISS: begin
        mul_a = AW'(s_mag[idx]);
        mul_b = 33'(max_speed);
      end
      S_DP_ISS: begin
        mul_a = AW'(vel[idx]);
        mul_b = 33'(cur.time_step);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rd_ctrl.start  = (state == S_ROOT_GO) || (state == S_DM_TAKE);
    rd_ctrl.is_div = (state == S_DM_TAKE);
    rd_ctrl.num    = (state == S_DM_TAKE) ? mul_p[63:0] : sum;
    rd_ctrl.den    = len;
    q_val = {{(PW-32){1'b0}}, rd_stat.res[31:0]};
    if (s_neg[idx]) q_val = -q_val;
  end

  vic_mul #(.AW(AW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  vic_rdiv u_rdiv (
    .clk  (clk),
    .rst  (rst),
    .ctrl (rd_ctrl),
    .stat (rd_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      idx          <= '0;
      k            <= '0;
      up_axis      <= vic_pkg::UP_AXIS_RST;
      forward_axis <= vic_pkg::FWD_AXIS_RST;
      right_axis   <= vic_pkg::RIGHT_AXIS_RST;
      max_speed    <= vic_pkg::MAX_SPEED_RST;
      for (int i = 0; i < 3; i++) begin
        vel[i]  <= '0;
        acc[i]  <= '0;
        disp[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          vic_pkg::REG_UP_AXIS:    up_axis      <= cfg_data;
          vic_pkg::REG_FWD_AXIS:   forward_axis <= cfg_data;
          vic_pkg::REG_RIGHT_AXIS: right_axis   <= cfg_data;
          vic_pkg::REG_MAX_SPEED:  max_speed    <= cfg_data[30:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur <= in_word;
            idx <= '0;
            for (int i = 0; i < 3; i++) disp[i] <= '0;
            unique case (in_word.opcode)
              vic_pkg::OP_DIR_ACC:  state <= S_AX_ISS;
              vic_pkg::OP_VEC_ACC:  state <= S_VACC;
              vic_pkg::OP_STEP:     state <= S_VADD;
              vic_pkg::OP_LOAD_VEL: begin
                vel[0] <= sat(PW'(in_word.vec_x));
                vel[1] <= sat(PW'(in_word.vec_y));
                vel[2] <= sat(PW'(in_word.vec_z));
                state  <= S_OUT;
              end
              vic_pkg::OP_LOAD_ACC: begin
                acc[0] <= sat(PW'(in_word.vec_x));
                acc[1] <= sat(PW'(in_word.vec_y));
                acc[2] <= sat(PW'(in_word.vec_z));
                state  <= S_OUT;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_AX_ISS: state <= dir_ok ? S_AX_TAKE : S_OUT;
        S_AX_TAKE: begin
          acc[idx] <= sat(PW'(acc[idx]) + PW'(sat(mul_p >>> 14)));
          idx      <= idx + 2'd1;
          state    <= (idx == 2'd2) ? S_OUT : S_AX_ISS;
        end
        S_VACC: begin
          acc[idx] <= sat(PW'(acc[idx]) + PW'(sat(PW'(vec_c))));
          idx      <= idx + 2'd1;
          if (idx == 2'd2) state <= S_OUT;
        end
        S_VADD: begin
          vel[idx] <= sat(PW'(vel[idx]) + PW'(acc[idx]));
          acc[idx] <= '0;
          idx      <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
          if (idx == 2'd2) begin
            state <= (max_speed == '0) ? S_DP_ISS : S_CHK;
          end
        end
        S_CHK: begin
          idx   <= '0;
          sum   <= '0;
          k     <= '0;
          state <= over ? S_SHIFT : S_SQ_ISS;
        end
        S_SQ_ISS: state <= S_SQ_TAKE;
        S_SQ_TAKE: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            state <= (sum > mul_p[63:0]) ? S_SHIFT : S_DP_ISS;
          end else begin
            sum   <= sum + mul_p[63:0];
            state <= S_SQ_ISS;
          end
        end
        S_SHIFT: begin
          if (big) begin
            k <= k + KW'(1);
          end else begin
            for (int i = 0; i < 3; i++) begin
              s_mag[i] <= sh_m[i][32:0];
              s_neg[i] <= sh_v[i][W-1];
            end
            idx   <= '0;
            sum   <= '0;
            state <= S_SQ2_ISS;
          end
        end
        S_SQ2_ISS: state <= S_SQ2_TAKE;
        S_SQ2_TAKE: begin
          sum   <= sum + mul_p[63:0];
          idx   <= idx + 2'd1;
          state <= (idx == 2'd2) ? S_ROOT_GO : S_SQ2_ISS;
        end
        S_ROOT_GO: state <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (rd_stat.done) begin
            idx   <= '0;
            len   <= rd_stat.res[33:0];
            state <= (rd_stat.res == '0) ? S_DP_ISS : S_DM_ISS;
          end
        end
        S_DM_ISS: state <= S_DM_TAKE;
        S_DM_TAKE: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (rd_stat.done) begin
            vel[idx] <= sat(q_val);
            idx      <= (idx == 2'd2) ? 2'd0 : idx + 2'd1;
            state    <= (idx == 2'd2) ? S_DP_ISS : S_DM_ISS;
          end
        end
        S_DP_ISS: state <= S_DP_TAKE;
        S_DP_TAKE: begin
          disp[idx] <= sat(mul_p >>> 16);
          idx       <= idx + 2'd1;
          state     <= (idx == 2'd2) ? S_OUT : S_DP_ISS;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_word.disp_x = 32'(disp[0]);
  assign out_word.disp_y = 32'(disp[1]);
  assign out_word.disp_z = 32'(disp[2]);
  assign out_word.vel_x  = 32'(vel[0]);
  assign out_word.vel_y  = 32'(vel[1]);
  assign out_word.vel_z  = 32'(vel[2]);
  assign out_word.acc_x  = 32'(acc[0]);
  assign out_word.acc_y  = 32'(acc[1]);
  assign out_word.acc_z  = 32'(acc[2]);

endmodule

/* sv/vic_checker.sv */
// ----------------------------------------------------------------------------
// vic_checker
// Port-level checks for the velocity integrator, bound to the top level.
// ----------------------------------------------------------------------------
module vic_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input vic_pkg::out_word_t out_word
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accept right after accept");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind velocity_integrator_speed_clamp vic_checker u_vic_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for velocity_integrator_speed_clamp. A queue-fed driver
// and a monitor run with random idle bursts on both sides; every result word
// is checked field by field against a local model of the integrator, the
// speed clamp and the displacement. Axis and speed-limit settings vary by
// phase and are written only while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  vic_pkg::in_word_t in_word;
  vic_pkg::out_word_t out_word;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;

  velocity_integrator_speed_clamp DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [47:0] up_ax, fwd_ax, right_ax;
  longint unsigned speed_lim;
  longint vel[3], acc[3];

  vic_pkg::in_word_t pending[$];
  vic_pkg::out_word_t expected[$];
  int errors = 0, n_sent = 0, n_seen = 0, n_clamped = 0;
  bit quiet = 0;
  bit took = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint sat(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void add_axis(logic [47:0] ax, longint amt);
    longint a, t;
    for (int i = 0; i < 3; i++) begin
      a = longint'($signed(ax[16*i +: 16]));
      t = sat(floor_shr(a * amt, 14));
      acc[i] = sat(acc[i] + t);
    end
  endfunction

  function automatic void clamp_speed();
    longint s[3];
    longint unsigned sum, len, lim, q;
    int k;
    bit over, big;
    if (speed_lim == 0) return;
    over = 0;
    for (int i = 0; i < 3; i++) if (magn(vel[i]) > speed_lim) over = 1;
    if (!over) begin
      sum = 0;
      for (int i = 0; i < 3; i++) sum += magn(vel[i]) * magn(vel[i]);
      if (sum <= speed_lim * speed_lim) return;
    end
    lim = 64'd1 << 31;
    k = 0;
    do begin
      big = 0;
      for (int i = 0; i < 3; i++) begin
        s[i] = floor_shr(vel[i], k);
        if (magn(s[i]) > lim) big = 1;
      end
      if (big) k++;
    end while (big && k < 63);
    sum = 0;
    for (int i = 0; i < 3; i++) sum += magn(s[i]) * magn(s[i]);
    len = root64(sum);
    if (len == 0) return;
    n_clamped++;
    for (int i = 0; i < 3; i++) begin
      q = magn(s[i]) * speed_lim / len;
      vel[i] = sat(s[i] < 0 ? -longint'(q) : longint'(q));
    end
  endfunction

  function automatic vic_pkg::out_word_t integrate(vic_pkg::in_word_t w);
    vic_pkg::out_word_t r;
    longint amt, v[3], d[3];
    amt = longint'(w.amount);
    v[0] = longint'(w.vec_x);
    v[1] = longint'(w.vec_y);
    v[2] = longint'(w.vec_z);
    d = '{0, 0, 0};
    case (w.opcode)
      vic_pkg::OP_DIR_ACC: begin
        case (w.direction)
          vic_pkg::DIR_FWD:   add_axis(fwd_ax, amt);
          vic_pkg::DIR_BACK:  add_axis(fwd_ax, -amt);
          vic_pkg::DIR_UP:    add_axis(up_ax, amt);
          vic_pkg::DIR_DOWN:  add_axis(up_ax, -amt);
          vic_pkg::DIR_RIGHT: add_axis(right_ax, amt);
          vic_pkg::DIR_LEFT:  add_axis(right_ax, -amt);
          default: ;
        endcase
      end
      vic_pkg::OP_VEC_ACC: for (int i = 0; i < 3; i++) acc[i] = sat(acc[i] + v[i]);
      vic_pkg::OP_STEP: begin
        for (int i = 0; i < 3; i++) begin
          vel[i] = sat(vel[i] + acc[i]);
          acc[i] = 0;
        end
        clamp_speed();
        for (int i = 0; i < 3; i++)
          d[i] = sat(floor_shr(vel[i] * longint'({1'b0, w.time_step}), 16));
      end
      vic_pkg::OP_LOAD_VEL: for (int i = 0; i < 3; i++) vel[i] = v[i];
      vic_pkg::OP_LOAD_ACC: for (int i = 0; i < 3; i++) acc[i] = v[i];
      default: ;
    endcase
    r.disp_x = 32'(d[0]); r.disp_y = 32'(d[1]); r.disp_z = 32'(d[2]);
    r.vel_x = 32'(vel[0]); r.vel_y = 32'(vel[1]); r.vel_z = 32'(vel[2]);
    r.acc_x = 32'(acc[0]); r.acc_y = 32'(acc[1]); r.acc_z = 32'(acc[2]);
    return r;
  endfunction

  // accept tracking
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected.push_back(integrate(in_word));
      n_sent++;
      took = 1;
    end
  end

  // driver
  int in_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || took) begin
      took = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 0;
      end else if (pending.size() > 0) begin
        in_word <= pending.pop_front();
        in_valid <= 1;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver stall
  int out_gap = 0;
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall <= 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_stall <= 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 7);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // monitor
  task automatic cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s expected %0d got %0d", name, $signed(e), $signed(a));
      errors++;
    end
  endtask

  always @(posedge clk) begin
    vic_pkg::out_word_t e;
    if (!rst && out_valid && !out_stall) begin
      n_seen++;
      if (expected.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = expected.pop_front();
        cmp("disp_x", e.disp_x, out_word.disp_x);
        cmp("disp_y", e.disp_y, out_word.disp_y);
        cmp("disp_z", e.disp_z, out_word.disp_z);
        cmp("vel_x", e.vel_x, out_word.vel_x);
        cmp("vel_y", e.vel_y, out_word.vel_y);
        cmp("vel_z", e.vel_z, out_word.vel_z);
        cmp("acc_x", e.acc_x, out_word.acc_x);
        cmp("acc_y", e.acc_y, out_word.acc_y);
        cmp("acc_z", e.acc_z, out_word.acc_z);
      end
    end
  end

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      vic_pkg::REG_UP_AXIS:    up_ax = val;
      vic_pkg::REG_FWD_AXIS:   fwd_ax = val;
      vic_pkg::REG_RIGHT_AXIS: right_ax = val;
      vic_pkg::REG_MAX_SPEED:  speed_lim = val[30:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] rval();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 3) - 1;
      3: return $urandom;
      default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
    endcase
  endfunction

  function automatic vic_pkg::in_word_t mk(logic [2:0] op, logic [2:0] dir,
                                           logic [31:0] a, logic [31:0] x,
                                           logic [31:0] y, logic [31:0] z,
                                           logic [15:0] ts);
    vic_pkg::in_word_t w;
    w.opcode = op; w.direction = dir; w.amount = a;
    w.vec_x = x; w.vec_y = y; w.vec_z = z; w.time_step = ts;
    return w;
  endfunction

  function automatic vic_pkg::in_word_t rand_word();
    int p;
    logic [2:0] op;
    p = $urandom_range(0, 99);
    if (p < 30) op = vic_pkg::OP_DIR_ACC;
    else if (p < 50) op = vic_pkg::OP_VEC_ACC;
    else if (p < 80) op = vic_pkg::OP_STEP;
    else if (p < 88) op = vic_pkg::OP_LOAD_VEL;
    else if (p < 96) op = vic_pkg::OP_LOAD_ACC;
    else op = 3'($urandom_range(5, 7));
    return mk(op, 3'($urandom_range(0, 7)), rval(), rval(), rval(), rval(),
              16'($urandom));
  endfunction

  function automatic logic [47:0] rand_axis();
    logic [47:0] a;
    a = 48'({$urandom, $urandom});
    if ($urandom_range(0, 1)) a[16*$urandom_range(0, 2) +: 16] = 16'h8000;
    return a;
  endfunction

  initial begin
    rst = 1;
    in_valid = 0; in_word = '0; out_stall = 0;
    cfg_valid = 0; cfg_index = vic_pkg::REG_UP_AXIS; cfg_data = '0;
    up_ax = vic_pkg::UP_AXIS_RST; fwd_ax = vic_pkg::FWD_AXIS_RST;
    right_ax = vic_pkg::RIGHT_AXIS_RST;
    speed_lim = vic_pkg::MAX_SPEED_RST;
    vel = '{0, 0, 0}; acc = '{0, 0, 0};
    repeat (4) @(posedge clk);
    @(negedge clk) rst = 0;

    // directed: every opcode and direction, extremes, saturation, odd codes
    for (int d = 0; d < 8; d++)
      pending.push_back(mk(vic_pkg::OP_DIR_ACC, 3'(d), 32'h00010000, 0, 0, 0, 0));
    pending.push_back(mk(vic_pkg::OP_DIR_ACC, vic_pkg::DIR_FWD, 32'h80000000, 0, 0, 0, 0));
    pending.push_back(mk(vic_pkg::OP_DIR_ACC, vic_pkg::DIR_BACK, 32'h80000000, 0, 0, 0, 0));
    pending.push_back(mk(vic_pkg::OP_VEC_ACC, 0, 0, 32'h7fffffff, 32'h80000000,
                         32'h7fffffff, 0));
    pending.push_back(mk(vic_pkg::OP_VEC_ACC, 0, 0, 32'h7fffffff, 32'h80000000,
                         32'h80000000, 0));
    pending.push_back(mk(vic_pkg::OP_STEP, 0, 0, 0, 0, 0, 16'hffff));
    pending.push_back(mk(vic_pkg::OP_LOAD_VEL, 0, 0, 32'h80000000, 32'h7fffffff,
                         32'hffffffff, 0));
    pending.push_back(mk(vic_pkg::OP_LOAD_ACC, 0, 0, 32'h80000000, 32'h80000000,
                         32'h80000000, 0));
    pending.push_back(mk(vic_pkg::OP_STEP, 0, 0, 0, 0, 0, 16'h0000));
    for (int o = 5; o < 8; o++) pending.push_back(mk(3'(o), 7, '1, '1, '1, '1, '1));
    pending.push_back(mk(vic_pkg::OP_STEP, 0, 0, 0, 0, 0, 16'h8000));
    drain();

    // speed exactly at the limit: 3-4-5 triangle, then just above
    write_reg(vic_pkg::REG_MAX_SPEED, 48'd5 << 16);
    pending.push_back(mk(vic_pkg::OP_LOAD_VEL, 0, 0, 3 << 16, 4 << 16, 0, 0));
    pending.push_back(mk(vic_pkg::OP_STEP, 0, 0, 0, 0, 0, 16'hffff));
    pending.push_back(mk(vic_pkg::OP_LOAD_ACC, 0, 0, 1, 0, 0, 0));
    pending.push_back(mk(vic_pkg::OP_STEP, 0, 0, 0, 0, 0, 16'h1000));
    pending.push_back(mk(vic_pkg::OP_LOAD_VEL, 0, 0, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 0));
    pending.push_back(mk(vic_pkg::OP_STEP, 0, 0, 0, 0, 0, 16'hffff));
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(vic_pkg::REG_UP_AXIS, ph == 0 ? 48'hffff_ffff_ffff : rand_axis());
      write_reg(vic_pkg::REG_FWD_AXIS, ph == 1 ? 48'h8000_8000_8000 : rand_axis());
      write_reg(vic_pkg::REG_RIGHT_AXIS, ph == 2 ? 48'h0 : rand_axis());
      case (ph)
        0: write_reg(vic_pkg::REG_MAX_SPEED, 48'h7fffffff);
        1: write_reg(vic_pkg::REG_MAX_SPEED, 48'd1);
        2: write_reg(vic_pkg::REG_MAX_SPEED, 48'd0);
        default: write_reg(vic_pkg::REG_MAX_SPEED, 48'($urandom_range(1, 32'h00ffffff)));
      endcase
      if (ph == 6) quiet = 1;
      for (int i = 0; i < 200; i++) pending.push_back(rand_word());
      // one hold-off in the middle of a phase until all results return
      if (ph == 3) begin
        while (pending.size() > 100) @(posedge clk);
        in_gap = 1000000;
        while (expected.size() > 0 || in_valid) @(posedge clk);
        in_gap = 0;
      end
      drain();
    end

    $display("Covered %0d words (%0d steps clamped) over 9 register settings",
             n_seen, n_clamped);
    if (errors == 0 && expected.size() == 0) begin
      $display("PASS velocity_integrator_speed_clamp");
    end else begin
      $display("FAIL velocity_integrator_speed_clamp");
    end
    $finish;
  end

  initial begin
    #(60ms);
    $display("FAIL velocity_integrator_speed_clamp");
    $finish;
  end
endmodule

/* files.f */
sv/vic_pkg.sv
sv/vic_mul.sv
sv/vic_rdiv.sv
sv/velocity_integrator_speed_clamp.sv
sv/vic_checker.sv
sim/tb.sv
